// File: rtl/shs_pkg.sv
// Types, round constants and initial hash values for the SHA-256 stream hasher.
package shs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_t;

    typedef logic [7:0][31:0] hstate_t;

    localparam logic [63:0][31:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    localparam hstate_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

endpackage

// File: rtl/sha256_stream_hasher.sv
// Top level: byte intake, padding and round sequencer, digest output.
// A plain byte is taken in idle; a byte that fills a block starts a compression
// (64 rounds on the shared round unit, then hash update and return to idle).
// An end item runs padding and one or two compressions, then
// 8 digest transfers, each of which out_stall can hold.
// Reset (rst_n low, asynchronous) loads the initial hash and clears counts.
module sha256_stream_hasher (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  shs_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output shs_pkg::out_t   out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COMP  = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [1:0] MODE_BLK  = 2'd0;
    localparam logic [1:0] MODE_MID  = 2'd1;
    localparam logic [1:0] MODE_LAST = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic             end_reg, end_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [63:0]      total_reg, total_next;
    logic [63:0]      len_reg, len_next;
    logic [2:0]       idx_reg, idx_next;
    shs_pkg::hstate_t h_reg, h_next;
    shs_pkg::hstate_t s_reg, s_next;
    logic [15:0][31:0] w_reg, w_next;

    shs_pkg::hstate_t s_round;
    logic [31:0]      w_new;
    logic [63:0]      len_now;
    logic             accept;
    logic [5:0]       pos;

    shs_round u_round (
        .s     (s_reg),
        .k     (shs_pkg::ROUND_K[rnd_reg]),
        .w0    (w_reg[0]),
        .w1    (w_reg[1]),
        .w9    (w_reg[9]),
        .w14   (w_reg[14]),
        .s_out (s_round),
        .w_new (w_new)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && !in_stall;
    assign len_now   = total_reg + {55'd0, cnt_reg, 3'd0};

    assign out_data.digest_word = h_reg[idx_reg];
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        end_next   = end_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        s_next     = s_reg;
        w_next     = w_reg;
        pos        = 6'd0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    end_next = in_data.end_of_message;
                    if (in_data.byte_valid)
                    begin
                        w_next[cnt_reg[5:2]][8*(3-cnt_reg[1:0]) +: 8] = in_data.data_byte;
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd63)
                        begin
                            mode_next  = MODE_BLK;
                            s_next     = h_reg;
                            rnd_next   = 6'd0;
                            state_next = ST_COMP;
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (in_data.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP:
            begin
                s_next = s_round;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + s_reg[i];
                end
                rnd_next = 6'd0;
                case (mode_reg)
                    MODE_BLK:
                    begin
                        total_next = total_reg + 64'd512;
                        cnt_next   = 6'd0;
                        state_next = end_reg ? ST_PAD : ST_IDLE;
                    end
                    MODE_MID:
                    begin
                        for (int i = 0; i < 14; i++)
                        begin
                            w_next[i] = 32'd0;
                        end
                        w_next[14] = len_reg[63:32];
                        w_next[15] = len_reg[31:0];
                        s_next     = h_next;
                        mode_next  = MODE_LAST;
                        state_next = ST_COMP;
                    end
                    default:
                    begin
                        idx_next   = 3'd0;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        pos = 6'(4 * i + b);
                        if (pos == cnt_reg)
                        begin
                            w_next[i][8*(3-b) +: 8] = 8'h80;
                        end
                        else if (pos > cnt_reg)
                        begin
                            w_next[i][8*(3-b) +: 8] = 8'h00;
                        end
                    end
                end
                len_next = len_now;
                s_next   = h_reg;
                rnd_next = 6'd0;
                if (cnt_reg >= 6'd56)
                begin
                    mode_next = MODE_MID;
                end
                else
                begin
                    w_next[14] = len_now[63:32];
                    w_next[15] = len_now[31:0];
                    mode_next  = MODE_LAST;
                end
                state_next = ST_COMP;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        h_next     = shs_pkg::INIT_H;
                        cnt_next   = 6'd0;
                        total_next = 64'd0;
                        end_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_BLK;
            end_reg   <= 1'b0;
            rnd_reg   <= 6'd0;
            cnt_reg   <= 6'd0;
            total_reg <= 64'd0;
            idx_reg   <= 3'd0;
            h_reg     <= shs_pkg::INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            end_reg   <= end_next;
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        s_reg   <= s_next;
        w_reg   <= w_next;
    end

`ifndef SYNTH
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest pending");
    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && rnd_reg != 6'd63) |=>
        (state_reg == ST_COMP && rnd_reg == $past(rnd_reg) + 6'd1))
        else $error("round counter skipped");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_word) |=> (!out_valid && cnt_reg == 6'd0))
        else $error("digest did not finish cleanly");
`endif

endmodule

// File: rtl/shs_round.sv
// One SHA-256 compression round and one message schedule step.
module shs_round (
    input  shs_pkg::hstate_t s,
    input  logic [31:0]      k,
    input  logic [31:0]      w0,
    input  logic [31:0]      w1,
    input  logic [31:0]      w9,
    input  logic [31:0]      w14,
    output shs_pkg::hstate_t s_out,
    output logic [31:0]      w_new
);

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] g0;
    logic [31:0] g1;

    always_comb
    begin
        t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + k + w0;
        t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        s_out[7] = s[6];
        s_out[6] = s[5];
        s_out[5] = s[4];
        s_out[4] = s[3] + t1;
        s_out[3] = s[2];
        s_out[2] = s[1];
        s_out[1] = s[0];
        s_out[0] = t1 + t2;
        g0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        g1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        w_new = g1 + w9 + g0 + w0;
    end

endmodule

// File: test/sha256_digest_checker.sv
// Digest predictor and checker for the SHA-256 stream hasher.
module sha256_digest_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  shs_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  shs_pkg::out_t out_data,
    output int            fail_count,
    output int            pending_words,
    output int            digests_seen
);

    logic [7:0]       msg_block [64];
    shs_pkg::hstate_t chain_h;
    int unsigned      fill;
    logic [63:0]      done_bits;
    shs_pkg::out_t    digest_queue[$];

    function automatic logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            x = w[i-15];
            y = w[i-2];
            w[i] = (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10)) + w[i-7]
                 + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-16];
        end
        for (int i = 0; i < 8; i++)
            s[i] = chain_h[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + shs_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + s[i];
    endtask

    task automatic absorb(shs_pkg::in_t item);
        logic [63:0]   bit_len;
        shs_pkg::out_t word;
        if (item.byte_valid)
        begin
            msg_block[fill] = item.data_byte;
            fill++;
            if (fill == 64)
            begin
                compress();
                done_bits += 64'd512;
                fill = 0;
            end
        end
        if (!item.end_of_message)
            return;
        bit_len = done_bits + 64'(fill * 8);
        msg_block[fill] = 8'h80;
        for (int i = fill + 1; i < 64; i++)
            msg_block[i] = 8'h00;
        if (fill >= 56)
        begin
            compress();
            for (int i = 0; i < 56; i++)
                msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bit_len[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            word.digest_word = chain_h[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_queue.push_back(word);
        end
        chain_h = shs_pkg::INIT_H;
        fill = 0;
        done_bits = '0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        digests_seen = 0;
        chain_h = shs_pkg::INIT_H;
        fill = 0;
        done_bits = '0;
    end

    assign pending_words = digest_queue.size();

    always @(posedge clk)
    begin
        shs_pkg::out_t want;
        if (rst_n && in_valid && !in_stall)
            absorb(in_data);
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
                report("unexpected transfer", out_data.digest_word, 32'h0);
            else
            begin
                want = digest_queue.pop_front();
                if (out_data.digest_word !== want.digest_word)
                    report("digest_word", out_data.digest_word, want.digest_word);
                if (out_data.word_index !== want.word_index)
                    report("word_index", 32'(out_data.word_index), 32'(want.word_index));
                if (out_data.last_word !== want.last_word)
                    report("last_word", 32'(out_data.last_word), 32'(want.last_word));
                if (want.last_word)
                    digests_seen++;
            end
        end
    end
endmodule

// File: test/tb.sv
// Stimulus and verdict for the SHA-256 stream hasher.
module tb;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    shs_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_stall;
    shs_pkg::out_t out_data;
    int   fail_count;
    int   pending_words;
    int   digests_seen;
    int   bytes_sent;
    bit   calm_phase;
    bit   hold_off;

    sha256_stream_hasher dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    sha256_digest_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data), .fail_count(fail_count),
        .pending_words(pending_words), .digests_seen(digests_seen)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("timeout");
        $display("tb failed");
        $finish;
    end

    // stall the result side at random, and once hold it off for a long stretch
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            out_stall <= !calm_phase && ($urandom_range(99) < 20);
        end
    end

    task automatic send(logic [7:0] b, logic bv, logic eom);
        while (!calm_phase && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (bv)
            bytes_sent++;
    endtask

    task automatic send_message(int len, bit with_end_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, with_end_byte && (i == len - 1));
        end
        if (!(with_end_byte && len > 0))
            send(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        int len;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        bytes_sent = 0;
        calm_phase = 1'b0;
        hold_off   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, idle item, extremes, short messages
        send(8'hff, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        send(8'hff, 1'b1, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'h00, 1'b1, 1'b1);
        send_message(3, 1'b0);
        send_message(4, 1'b1);
        drain();

        // padding that needs the extra block, and one exact block
        send_message(56, 1'b1);
        calm_phase = 1'b1;
        send_message(64, 1'b0);
        calm_phase = 1'b0;
        send_message(55, 1'b1);
        drain();

        // result side held off while further messages wait at the stalled input
        hold_off = 1'b1;
        for (int m = 0; m < 6; m++)
            send_message($urandom_range(2, 1), 1'($urandom_range(1)));
        drain();

        while (bytes_sent < 200)
        begin
            len = $urandom_range(12);
            send_message(len, 1'($urandom_range(1)));
        end
        drain();

        $display("sent %0d message bytes, checked %0d digests", bytes_sent, digests_seen);
        $display("covered empty messages, padding overflow, multi-block and stalled output");
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// File: sha256_stream_hasher.f
rtl/shs_pkg.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher.sv
test/sha256_digest_checker.sv
test/tb.sv
